FILE: sv/rcld_pkg.sv
// ----------------------------------------------------------------------------
// rcld_pkg
// Shared types and constants of the repeated click loop detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rcld_pkg;

	// default ring depth
	localparam int RING_DEPTH_DEF = 64;

	// field widths
	localparam int POS_W   = 16;
	localparam int TIME_W  = 32;
	localparam int WIN_W   = 16;
	localparam int PROX_W  = 12;
	localparam int REP_W   = 7;
	localparam int CNT_O_W = 7;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;
	localparam logic [CFG_AW-1:0] REG_WINDOW_MS    = 2'd0;
	localparam logic [CFG_AW-1:0] REG_PROXIMITY_PX = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MAX_REPEATS  = 2'd2;

	// register reset values
	localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd1000;
	localparam logic [PROX_W-1:0] PROX_RST   = 12'd5;
	localparam logic [REP_W-1:0]  REP_RST    = 7'd5;

	// item kind on tuser
	localparam logic OP_CLICK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// stream widths
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 16;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP_RD,
		ST_DROP_CHK,
		ST_PLACE,
		ST_WRITE,
		ST_SCAN_RD,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/repeated_click_loop_detector.sv
// ----------------------------------------------------------------------------
// repeated_click_loop_detector
// Counts recent clicks near each new click over a ring of stored clicks and
// trips a sticky halt latch when the count reaches the configured limit.
// ----------------------------------------------------------------------------
// a clear or a click while halted goes straight to the result; other clicks age out old
//   entries, append, then scan the ring, squaring dx and dy of each stored entry on one
//   squaring multiplier shared over the scan, with one read port; an item is taken only
//   in idle, so no new item is accepted until the last result is registered for output
// reset: ring empty, halt latch clear, registers at their reset values; ring
//   contents are not cleared
`default_nettype none

module repeated_click_loop_detector #(
	parameter int RING_DEPTH = rcld_pkg::RING_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [rcld_pkg::CFG_AW-1:0]       cfg_addr,
	input  wire logic [rcld_pkg::CFG_DW-1:0]       cfg_wdata,
	// input stream
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// pos_x [15:0], pos_y [31:16], time_ms [63:32]
	input  wire logic [rcld_pkg::S_TDATA_W-1:0]    s_tdata,
	// op [0]
	input  wire logic                              s_tuser,
	// result stream
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// allowed [0], halted [1], newly_tripped [2], nearby_count [9:3], zero [15:10]
	output      logic [rcld_pkg::M_TDATA_W-1:0]    m_tdata
);

	import rcld_pkg::*;

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int EW = 2 * POS_W + TIME_W;

	// configuration registers
	logic [WIN_W-1:0]  window_q;
	logic [PROX_W-1:0] prox_q;
	logic [REP_W-1:0]  max_rep_q;

	// captured item
	logic              op_q;
	logic [POS_W-1:0]  in_x_q;
	logic [POS_W-1:0]  in_y_q;
	logic [TIME_W-1:0] in_time_q;

	// ring control
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] cnt_q;
	logic          halt_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] k_q;

	// ring storage and read register
	logic [EW-1:0] ring_q [RING_DEPTH];
	logic [EW-1:0] rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] slot;

	// scan datapath
	logic signed [POS_W:0]     mul_a;
	logic signed [2*POS_W+1:0] prod;
	logic [2*PROX_W-1:0]       r2_q;
	logic [2*POS_W:0]          sqx_q;
	logic [2*POS_W:0]          sqy_q;
	logic                      pend_q;
	logic [CW-1:0]             hits_q;
	logic                      near;
	logic [CW-1:0]             hits_fin;

	// result registers
	logic               res_allowed_q;
	logic               res_halted_q;
	logic               res_trip_q;
	logic [CNT_O_W-1:0] res_cnt_q;
	logic               out_allowed_q;
	logic               out_halted_q;
	logic               out_trip_q;
	logic [CNT_O_W-1:0] out_cnt_q;
	logic               m_tvalid_q;

	state_t state_q, state_d;

	// helpers
	logic [AW-1:0]   oldest_nxt;
	logic [AW-1:0]   ptr_nxt;
	logic [AW:0]     slot_sum;
	logic [TIME_W-1:0] age;
	logic            aged_out;
	logic signed [POS_W:0] dx;
	logic signed [POS_W:0] dy;
	logic            out_free;
	logic            s_xfer;

	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// ring pointer wrap
	assign oldest_nxt = (oldest_q == AW'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign ptr_nxt    = (ptr_q == AW'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign slot_sum   = (AW+1)'(oldest_q) + (AW+1)'(cnt_q);
	assign slot       = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
		AW'(slot_sum - (AW+1)'(RING_DEPTH)) : AW'(slot_sum);

	// window age of the oldest entry
	assign age      = in_time_q - rd_q[EW-1 -: TIME_W];
	assign aged_out = age > TIME_W'(window_q);

	// coordinate differences against the read entry
	assign dx = $signed({rd_q[POS_W-1], rd_q[POS_W-1:0]}) -
		$signed({in_x_q[POS_W-1], in_x_q});
	assign dy = $signed({rd_q[2*POS_W-1], rd_q[2*POS_W-1:POS_W]}) -
		$signed({in_y_q[POS_W-1], in_y_q});

	// shared squaring unit
	always_comb begin
		unique case (state_q)
			ST_SCAN_RD: mul_a = $signed({{(POS_W+1-PROX_W){1'b0}}, prox_q});
			ST_SQY:     mul_a = dy;
			default:    mul_a = dx;
		endcase
	end
	assign prod = mul_a * mul_a;

	// distance test of the entry whose two squares are held
	assign near     = ((2*POS_W+2)'(sqx_q) + (2*POS_W+2)'(sqy_q)) <= (2*POS_W+2)'(r2_q);
	assign hits_fin = hits_q + CW'(near);

	// next state and memory strobes
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					if (s_tuser == OP_CLEAR || halt_q)
						state_d = ST_DONE;
					else
						state_d = ST_DROP_RD;
				end
			end
			ST_DROP_RD: begin
				rd_addr = oldest_q;
				if (cnt_q != '0) begin
					rd_en   = 1'b1;
					state_d = ST_DROP_CHK;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_DROP_CHK: begin
				state_d = aged_out ? ST_DROP_RD : ST_PLACE;
			end
			ST_PLACE: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				rd_en   = 1'b1;
				state_d = ST_SQX;
			end
			ST_SQX: begin
				state_d = ST_SQY;
			end
			ST_SQY: begin
				if (k_q < cnt_q) begin
					rd_en   = 1'b1;
					state_d = ST_SQX;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RST;
			prox_q    <= PROX_RST;
			max_rep_q <= REP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WINDOW_MS:    window_q  <= cfg_wdata[WIN_W-1:0];
				REG_PROXIMITY_PX: prox_q    <= cfg_wdata[PROX_W-1:0];
				REG_MAX_REPEATS:  max_rep_q <= cfg_wdata[REP_W-1:0];
				default: ;
			endcase
		end
	end

	// ring storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			ring_q[slot] <= {in_time_q, in_y_q, in_x_q};
		if (rd_en)
			rd_q <= ring_q[rd_addr];
	end

	// captured item and scan datapath
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_q      <= s_tuser;
			in_x_q    <= s_tdata[POS_W-1:0];
			in_y_q    <= s_tdata[2*POS_W-1:POS_W];
			in_time_q <= s_tdata[EW-1 -: TIME_W];
		end
		if (state_q == ST_SCAN_RD)
			r2_q <= prod[2*PROX_W-1:0];
		if (state_q == ST_SQX)
			sqx_q <= prod[2*POS_W:0];
		if (state_q == ST_SQY)
			sqy_q <= prod[2*POS_W:0];
	end

	// ring control, halt latch and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q      <= '0;
			cnt_q         <= '0;
			halt_q        <= 1'b0;
			ptr_q         <= '0;
			k_q           <= '0;
			pend_q        <= 1'b0;
			hits_q        <= '0;
			res_allowed_q <= 1'b0;
			res_halted_q  <= 1'b0;
			res_trip_q    <= 1'b0;
			res_cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						res_allowed_q <= 1'b0;
						res_trip_q    <= 1'b0;
						res_cnt_q     <= '0;
						if (s_tuser == OP_CLEAR) begin
							oldest_q     <= '0;
							cnt_q        <= '0;
							halt_q       <= 1'b0;
							res_halted_q <= 1'b0;
						end else begin
							res_halted_q <= 1'b1;
						end
					end
				end
				// age out the oldest entry
				ST_DROP_CHK: begin
					if (aged_out) begin
						oldest_q <= oldest_nxt;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				// make room in a full ring
				ST_PLACE: begin
					if (cnt_q == CW'(RING_DEPTH)) begin
						oldest_q <= oldest_nxt;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q + 1'b1;
					ptr_q <= oldest_q;
				end
				ST_SCAN_RD: begin
					ptr_q  <= ptr_nxt;
					k_q    <= CW'(1);
					hits_q <= '0;
					pend_q <= 1'b0;
				end
				// retire the previous entry while squaring dx of this one
				ST_SQX: begin
					if (pend_q)
						hits_q <= hits_fin;
					pend_q <= 1'b0;
				end
				ST_SQY: begin
					pend_q <= 1'b1;
					if (k_q < cnt_q) begin
						ptr_q <= ptr_nxt;
						k_q   <= k_q + 1'b1;
					end
				end
				// last entry and trip decision
				ST_CMP: begin
					hits_q    <= hits_fin;
					pend_q    <= 1'b0;
					res_cnt_q <= (32'(hits_fin) > 32'((1 << CNT_O_W) - 1)) ?
						CNT_O_W'((1 << CNT_O_W) - 1) : CNT_O_W'(hits_fin);
					if (32'(hits_fin) >= 32'(max_rep_q)) begin
						halt_q        <= 1'b1;
						res_allowed_q <= 1'b0;
						res_halted_q  <= 1'b1;
						res_trip_q    <= 1'b1;
					end else begin
						res_allowed_q <= 1'b1;
						res_halted_q  <= 1'b0;
						res_trip_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_allowed_q <= res_allowed_q;
			out_halted_q  <= res_halted_q;
			out_trip_q    <= res_trip_q;
			out_cnt_q     <= (op_q == OP_CLEAR) ? '0 : res_cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-3-CNT_O_W){1'b0}}, out_cnt_q, out_trip_q,
		out_halted_q, out_allowed_q};

	// ring never holds more than its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(RING_DEPTH))
		else $error("ring fill above depth");

	// oldest pointer stays inside the ring
	a_oldest_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(oldest_q) < 32'(RING_DEPTH))
		else $error("oldest pointer out of range");

	// a trip leaves the latch set and refuses the click
	a_trip_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && 32'(hits_fin) >= 32'(max_rep_q)) |=> halt_q && !res_allowed_q)
		else $error("trip without halt");

	// an allowed click always counts at least itself
	a_allowed_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[9:3] != 7'd0 && !m_tdata[1]))
		else $error("allowed click with empty count");

	// scan stays within the stored entries
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQX || state_q == ST_SQY) |-> (k_q <= cnt_q && k_q != '0))
		else $error("scan index beyond fill");

endmodule

`default_nettype wire
